/* src/xxh64_pkg.sv */
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared constants, types and helpers of the XXH64 stream hash.
// ----------------------------------------------------------------------------
package xxh64_pkg;

	localparam int unsigned LengthBitsDefault = 64;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NOP       = 5'd0,
		OP_START     = 5'd1,  // load lanes from seed, clear length and buffer
		OP_ABSORB    = 5'd2,  // capture word, add length, push if full
		OP_LANE_MUL2 = 5'd3,  // prod = buf[idx] * P2
		OP_LANE_FIN  = 5'd4,  // prod = rotl(lane+prod,31) * P1
		OP_MRG_INIT  = 5'd5,  // h = rotl sum of lanes, or seed + P5
		OP_MRG_MUL2  = 5'd6,  // prod = lane[idx] * P2
		OP_MRG_MUL1  = 5'd7,  // prod = rotl(prod,31) * P1
		OP_MRG_XMUL  = 5'd8,  // prod = (h ^ prod) * P1
		OP_MRG_ADD   = 5'd9,  // h = prod + P4
		OP_ADD_LEN   = 5'd10, // h += length
		OP_TW_MUL2   = 5'd11, // prod = buf[idx] * P2
		OP_TW_MUL1   = 5'd12, // prod = rotl(prod,31) * P1
		OP_TW_XMUL   = 5'd13, // prod = rotl(h ^ prod,27) * P1
		OP_TD_MUL    = 5'd14, // prod = word[31:0] * P1
		OP_TD_XMUL   = 5'd15, // prod = rotl(h ^ prod,23) * P2
		OP_TD_ADD    = 5'd16, // h = prod + P3
		OP_TB_MUL    = 5'd17, // prod = byte[idx] * P5
		OP_TB_XMUL   = 5'd18, // prod = rotl(h ^ prod,11) * P1
		OP_H_FROM_P  = 5'd19, // h = prod, plus P4 when idx[3] is set
		OP_AV_MUL2   = 5'd20, // prod = (h ^ h>>33) * P2
		OP_AV_MUL3   = 5'd21, // prod = (prod ^ prod>>29) * P3
		OP_AV_OUT    = 5'd22, // h = prod ^ prod>>32
		OP_LANE_WR   = 5'd23  // lane[idx] = prod
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic [3:0]  idx;
	} dp_cmd_t;

	typedef struct packed {
		logic        long_msg;
		logic        push_full;   // absorb completed a stripe
		logic [1:0]  nwords;      // full words pending in the buffer
		logic [3:0]  cnt;         // bytes of the last word, 0..8
	} dp_status_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		rotl64 = (x << r) | (x >> (64 - r));
	endfunction

endpackage

/* src/xxh64_stream_hash.sv */
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// XXH64 hash of a message streamed as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Words arrive one beat at a time on the input channel; byte_count gives the
// bytes held by the last beat (0..8) and is taken as 8 on every other beat.
// The seed register is sampled at the first beat of each message and may
// only be written while the block is idle. Each beat passes an absorb and a
// check state before the next beat is taken. All arithmetic shares one 64-bit
// multiplier made of 32x32 partial products, registered first and then summed
// into the product register. A beat that completes a 32-byte stripe also runs
// the four lane rounds. The last beat then runs the lane merge (long messages
// only), a round per pending full word, a four-byte tail step, a step per tail
// byte and the avalanche before the digest beat is offered. The next message
// is taken once the digest beat has gone.
// ----------------------------------------------------------------------------
module xxh64_stream_hash #(
	parameter int unsigned LENGTH_BITS = xxh64_pkg::LengthBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// seed write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	// word input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] word_data,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	// digest output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	xxh64_pkg::dp_cmd_t    cmd;
	xxh64_pkg::dp_status_t status;
	logic [63:0] seed_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic        last_q;
	logic        busy;

	// seed register: always ready, writes are only legal while idle
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// hold the accepted beat for the absorb step
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_q <= word_data;
			cnt_q  <= byte_count;
			last_q <= last_word;
		end
	end

	xxh64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_last   (last_word),
		.status    (status),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.busy      (busy)
	);

	xxh64_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed       (seed_q),
		.word_data  (word_q),
		.byte_count (cnt_q),
		.last_word  (last_q),
		.status     (status),
		.hash       (digest)
	);

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("input open while busy");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(digest)) else $error("digest moved while stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("digest dropped");

endmodule

/* src/xxh64_datapath.sv */
// ----------------------------------------------------------------------------
// xxh64_datapath
// Lane accumulators, stripe buffer, length counter and one shared
// 64x64 (low half) multiplier, built from three 32x32 partial products;
// the partial products are registered, then summed into the product register.
// ----------------------------------------------------------------------------
module xxh64_datapath #(
	parameter int unsigned LENGTH_BITS = xxh64_pkg::LengthBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xxh64_pkg::dp_cmd_t   cmd,
	input  logic [63:0]          seed,
	input  logic [63:0]          word_data,
	input  logic [3:0]           byte_count,
	input  logic                 last_word,
	output xxh64_pkg::dp_status_t status,
	output logic [63:0]          hash
);

	logic [63:0]            lane_q [4];
	logic [63:0]            buf_q  [4];
	logic [63:0]            word_q;
	logic [3:0]             cnt_q;
	logic [2:0]             fill_q;   // words in buffer, 0..4
	logic [LENGTH_BITS-1:0] len_q;
	logic                   long_q;
	logic [63:0]            h_q;
	logic [63:0]            prod_q;
	logic [63:0]            pp_ll_s1;
	logic [31:0]            pp_lh_s1;
	logic [31:0]            pp_hl_s1;

	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic [63:0] hx;
	logic [3:0]  cnt_in;

	assign hx = h_q ^ prod_q;
	assign cnt_in = (!last_word || byte_count > 4'd8) ? 4'd8 : byte_count;

	always_comb begin
		mul_a = '0;
		mul_b = xxh64_pkg::P1;
		case (cmd.op)
			xxh64_pkg::OP_LANE_MUL2, xxh64_pkg::OP_TW_MUL2: begin
				mul_a = buf_q[cmd.idx[1:0]];
				mul_b = xxh64_pkg::P2;
			end
			xxh64_pkg::OP_LANE_FIN:
				mul_a = xxh64_pkg::rotl64(lane_q[cmd.idx[1:0]] + prod_q, 31);
			xxh64_pkg::OP_MRG_MUL2: begin
				mul_a = lane_q[cmd.idx[1:0]];
				mul_b = xxh64_pkg::P2;
			end
			xxh64_pkg::OP_MRG_MUL1, xxh64_pkg::OP_TW_MUL1:
				mul_a = xxh64_pkg::rotl64(prod_q, 31);
			xxh64_pkg::OP_MRG_XMUL:
				mul_a = hx;
			xxh64_pkg::OP_TW_XMUL:
				mul_a = xxh64_pkg::rotl64(hx, 27);
			xxh64_pkg::OP_TD_MUL:
				mul_a = {32'd0, word_q[31:0]};
			xxh64_pkg::OP_TD_XMUL: begin
				mul_a = xxh64_pkg::rotl64(hx, 23);
				mul_b = xxh64_pkg::P2;
			end
			xxh64_pkg::OP_TB_MUL: begin
				mul_a = {56'd0, word_q[{cmd.idx[2:0], 3'b000} +: 8]};
				mul_b = xxh64_pkg::P5;
			end
			xxh64_pkg::OP_TB_XMUL:
				mul_a = xxh64_pkg::rotl64(hx, 11);
			xxh64_pkg::OP_AV_MUL2: begin
				mul_a = h_q ^ (h_q >> 33);
				mul_b = xxh64_pkg::P2;
			end
			xxh64_pkg::OP_AV_MUL3: begin
				mul_a = prod_q ^ (prod_q >> 29);
				mul_b = xxh64_pkg::P3;
			end
			default: ;
		endcase
	end

	// partial products first, then the low 64 bits are summed
	always_ff @(posedge clk) begin
		pp_ll_s1 <= {32'd0, mul_a[31:0]} * {32'd0, mul_b[31:0]};
		pp_lh_s1 <= mul_a[31:0] * mul_b[63:32];
		pp_hl_s1 <= mul_a[63:32] * mul_b[31:0];
		prod_q   <= pp_ll_s1 + {pp_lh_s1 + pp_hl_s1, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			long_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (cmd.op)
				xxh64_pkg::OP_START: begin
					fill_q <= '0;
					len_q  <= '0;
					long_q <= 1'b0;
				end
				xxh64_pkg::OP_ABSORB: begin
					cnt_q <= cnt_in;
					len_q <= len_q + LENGTH_BITS'(cnt_in);
					if (cnt_in == 4'd8) begin
						fill_q <= fill_q + 3'd1;
					end
				end
				xxh64_pkg::OP_LANE_FIN: begin
					if (cmd.idx[1:0] == 2'd3) begin
						fill_q <= '0;
						long_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			xxh64_pkg::OP_START: begin
				lane_q[0] <= seed + xxh64_pkg::P1 + xxh64_pkg::P2;
				lane_q[1] <= seed + xxh64_pkg::P2;
				lane_q[2] <= seed;
				lane_q[3] <= seed - xxh64_pkg::P1;
			end
			xxh64_pkg::OP_ABSORB: begin
				word_q <= word_data;
				if (cnt_in == 4'd8) begin
					buf_q[fill_q[1:0]] <= word_data;
				end
			end
			xxh64_pkg::OP_LANE_WR:
				lane_q[cmd.idx[1:0]] <= prod_q;
			xxh64_pkg::OP_MRG_INIT:
				h_q <= long_q ?
					xxh64_pkg::rotl64(lane_q[0], 1) + xxh64_pkg::rotl64(lane_q[1], 7) +
					xxh64_pkg::rotl64(lane_q[2], 12) + xxh64_pkg::rotl64(lane_q[3], 18)
					: lane_q[2] + xxh64_pkg::P5;
			xxh64_pkg::OP_MRG_ADD, xxh64_pkg::OP_TW_XMUL:
				;
			xxh64_pkg::OP_ADD_LEN:
				h_q <= h_q + 64'(len_q);
			xxh64_pkg::OP_TD_ADD:
				h_q <= prod_q + xxh64_pkg::P3;
			xxh64_pkg::OP_H_FROM_P:
				h_q <= prod_q + (cmd.idx[3] ? xxh64_pkg::P4 : 64'd0);
			xxh64_pkg::OP_AV_OUT:
				h_q <= prod_q ^ (prod_q >> 32);
			default: ;
		endcase
		if (cmd.op == xxh64_pkg::OP_MRG_ADD) begin
			h_q <= prod_q + xxh64_pkg::P4;
		end
	end

	assign status.long_msg  = long_q;
	assign status.push_full = (fill_q == 3'd4);
	assign status.nwords    = fill_q[1:0];
	assign status.cnt       = cnt_q;
	assign hash             = h_q;

endmodule

/* src/xxh64_ctrl.sv */
// ----------------------------------------------------------------------------
// xxh64_ctrl
// Sequencer: issues datapath micro-ops for absorb, stripe fold and finalise.
// ----------------------------------------------------------------------------
module xxh64_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  in_last,
	input  xxh64_pkg::dp_status_t status,
	output xxh64_pkg::dp_cmd_t    cmd,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_ABS, S_CHK, S_LMUL2, S_LFIN, S_LWR,
		S_MINIT, S_MM2, S_MM1, S_MXM, S_MADD, S_LEN,
		S_WM2, S_WM1, S_WXM, S_WADD,
		S_DCHK, S_DMUL, S_DXM, S_DADD,
		S_BCHK, S_BMUL, S_BXM, S_BH,
		S_AV2, S_AV3, S_AVO, S_OUT
	} state_t;

	state_t     state_q;
	logic       started_q;
	logic       last_q;
	logic [1:0] i_q;
	logic [3:0] pos_q;
	logic       wait_q;
	logic       mul_wait;
	logic       accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign busy     = (state_q != S_IDLE);

	// states that start a multiply hold in a wait state until the product is ready
	assign mul_wait = state_q inside {S_LMUL2, S_LFIN, S_MM2, S_MM1, S_MXM,
		S_WM2, S_WM1, S_WXM, S_DMUL, S_DXM, S_BMUL, S_BXM, S_AV2, S_AV3};

	always_comb begin
		cmd.op  = xxh64_pkg::OP_NOP;
		cmd.idx = {2'b00, i_q};
		unique case (state_q)
			S_IDLE:  cmd.op = (accept && !started_q) ? xxh64_pkg::OP_START : xxh64_pkg::OP_NOP;
			S_ABS:   cmd.op = xxh64_pkg::OP_ABSORB;
			S_LMUL2: cmd.op = xxh64_pkg::OP_LANE_MUL2;
			S_LFIN:  cmd.op = xxh64_pkg::OP_LANE_FIN;
			S_LWR:   cmd.op = xxh64_pkg::OP_LANE_WR;
			S_MINIT: cmd.op = xxh64_pkg::OP_MRG_INIT;
			S_MM2:   cmd.op = xxh64_pkg::OP_MRG_MUL2;
			S_MM1:   cmd.op = xxh64_pkg::OP_MRG_MUL1;
			S_MXM:   cmd.op = xxh64_pkg::OP_MRG_XMUL;
			S_MADD:  cmd.op = xxh64_pkg::OP_MRG_ADD;
			S_LEN:   cmd.op = xxh64_pkg::OP_ADD_LEN;
			S_WM2:   cmd.op = xxh64_pkg::OP_TW_MUL2;
			S_WM1:   cmd.op = xxh64_pkg::OP_TW_MUL1;
			S_WXM:   cmd.op = xxh64_pkg::OP_TW_XMUL;
			S_WADD: begin
				cmd.op  = xxh64_pkg::OP_H_FROM_P;
				cmd.idx = 4'b1000;
			end
			S_DMUL:  cmd.op = xxh64_pkg::OP_TD_MUL;
			S_DXM:   cmd.op = xxh64_pkg::OP_TD_XMUL;
			S_DADD:  cmd.op = xxh64_pkg::OP_TD_ADD;
			S_BMUL: begin
				cmd.op  = xxh64_pkg::OP_TB_MUL;
				cmd.idx = pos_q;
			end
			S_BXM:   cmd.op = xxh64_pkg::OP_TB_XMUL;
			S_BH: begin
				cmd.op  = xxh64_pkg::OP_H_FROM_P;
				cmd.idx = 4'b0000;
			end
			S_AV2:   cmd.op = xxh64_pkg::OP_AV_MUL2;
			S_AV3:   cmd.op = xxh64_pkg::OP_AV_MUL3;
			S_AVO:   cmd.op = xxh64_pkg::OP_AV_OUT;
			default: cmd.op = xxh64_pkg::OP_NOP;
		endcase
		if (wait_q) begin
			cmd.op = xxh64_pkg::OP_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			last_q    <= 1'b0;
			i_q       <= '0;
			pos_q     <= '0;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
		end else if (mul_wait && !wait_q) begin
			wait_q <= 1'b1;
		end else begin
			wait_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					state_q   <= S_ABS;
					started_q <= 1'b1;
					last_q    <= in_last;
				end
				S_ABS: state_q <= S_CHK;
				S_CHK: begin
					i_q <= '0;
					if (status.push_full) state_q <= S_LMUL2;
					else if (last_q) state_q <= S_MINIT;
					else state_q <= S_IDLE;
				end
				S_LMUL2: state_q <= S_LFIN;
				S_LFIN:  state_q <= S_LWR;
				S_LWR: begin
					i_q <= i_q + 2'd1;
					if (i_q == 2'd3) state_q <= last_q ? S_MINIT : S_IDLE;
					else state_q <= S_LMUL2;
				end
				S_MINIT: begin
					i_q <= '0;
					state_q <= status.long_msg ? S_MM2 : S_LEN;
				end
				S_MM2: state_q <= S_MM1;
				S_MM1: state_q <= S_MXM;
				S_MXM: state_q <= S_MADD;
				S_MADD: begin
					i_q <= i_q + 2'd1;
					state_q <= (i_q == 2'd3) ? S_LEN : S_MM2;
				end
				S_LEN: begin
					i_q <= '0;
					state_q <= (status.nwords != 2'd0) ? S_WM2 : S_DCHK;
				end
				S_WM2: state_q <= S_WM1;
				S_WM1: state_q <= S_WXM;
				S_WXM: state_q <= S_WADD;
				S_WADD: begin
					i_q <= i_q + 2'd1;
					state_q <= (i_q + 2'd1 == status.nwords) ? S_DCHK : S_WM2;
				end
				S_DCHK: begin
					pos_q <= '0;
					if (status.cnt >= 4'd4 && status.cnt < 4'd8) state_q <= S_DMUL;
					else if (status.cnt < 4'd8) state_q <= S_BCHK;
					else state_q <= S_AV2;
				end
				S_DMUL: state_q <= S_DXM;
				S_DXM:  state_q <= S_DADD;
				S_DADD: begin
					pos_q <= 4'd4;
					state_q <= S_BCHK;
				end
				S_BCHK: state_q <= (pos_q < status.cnt) ? S_BMUL : S_AV2;
				S_BMUL: state_q <= S_BXM;
				S_BXM:  state_q <= S_BH;
				S_BH: begin
					pos_q <= pos_q + 4'd1;
					state_q <= S_BCHK;
				end
				S_AV2: state_q <= S_AV3;
				S_AV3: state_q <= S_AVO;
				S_AVO: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					started_q <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("digest valid outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept) else $error("word taken while busy");
	a_out_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("digest repeated");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XXH64 stream hash.
// ----------------------------------------------------------------------------
// Messages are queued as word beats by the stimulus process and driven by a
// clocked driver with random gaps; a clocked monitor takes digest beats under
// random stall and compares them against a behavioural XXH64 computed from
// the accepted beats. The seed is rewritten between message groups while the
// block is idle.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
	} word_beat_t;

	localparam int unsigned WatchdogLimit = 20000;
	localparam int unsigned DrainCycles   = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] word_data;
	logic [3:0]  byte_count;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest;

	word_beat_t  pending_beats[$];
	logic [63:0] expected_digests[$];
	int unsigned error_count;
	int unsigned quiet_cycles;
	bit          idle_free;     // suppress random idling on both sides
	bit          hold_sender;   // sender pauses until the digests are in

	// predictor state
	logic [63:0] hash_seed;
	logic [63:0] lane[4];
	logic [63:0] stripe[4];
	int unsigned fill_words;
	logic [63:0] msg_len;
	bit          folded;
	bit          in_message;

	xxh64_stream_hash i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.word_data  (word_data),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digest     (digest)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rot_left(logic [63:0] x, int unsigned r);
		return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
	endfunction

	function automatic logic [63:0] xx_round(logic [63:0] acc, logic [63:0] v);
		return rot_left(acc + v * xxh64_pkg::P2, 31) * xxh64_pkg::P1;
	endfunction

	// absorb one accepted beat; a digest is pushed on the last beat
	task automatic absorb_beat(word_beat_t b);
		logic [63:0] h;
		int unsigned n;
		int unsigned pos;
		if (!in_message) begin
			lane[0] = hash_seed + xxh64_pkg::P1 + xxh64_pkg::P2;
			lane[1] = hash_seed + xxh64_pkg::P2;
			lane[2] = hash_seed;
			lane[3] = hash_seed - xxh64_pkg::P1;
			fill_words = 0;
			msg_len = '0;
			folded = 1'b0;
			in_message = 1'b1;
		end
		n = (b.cnt > 8 || !b.last) ? 8 : b.cnt;
		msg_len += n;
		if (n == 8) begin
			stripe[fill_words] = b.data;
			fill_words++;
			if (fill_words == 4) begin
				for (int i = 0; i < 4; i++)
					lane[i] = xx_round(lane[i], stripe[i]);
				fill_words = 0;
				folded = 1'b1;
			end
		end
		if (b.last) begin
			if (folded) begin
				h = rot_left(lane[0], 1) + rot_left(lane[1], 7) +
					rot_left(lane[2], 12) + rot_left(lane[3], 18);
				for (int i = 0; i < 4; i++)
					h = (h ^ xx_round(0, lane[i])) * xxh64_pkg::P1 + xxh64_pkg::P4;
			end else begin
				h = lane[2] + xxh64_pkg::P5;
			end
			h += msg_len;
			for (int i = 0; i < fill_words; i++)
				h = rot_left(h ^ xx_round(0, stripe[i]), 27) * xxh64_pkg::P1 +
					xxh64_pkg::P4;
			if (n < 8) begin
				pos = 0;
				if (n >= 4) begin
					h = rot_left(h ^ (b.data[31:0] * xxh64_pkg::P1), 23) * xxh64_pkg::P2 +
						xxh64_pkg::P3;
					pos = 4;
				end
				for (; pos < n; pos++)
					h = rot_left(h ^ ({56'd0, b.data[8*pos +: 8]} * xxh64_pkg::P5), 11) *
						xxh64_pkg::P1;
			end
			h ^= h >> 33;
			h *= xxh64_pkg::P2;
			h ^= h >> 29;
			h *= xxh64_pkg::P3;
			h ^= h >> 32;
			expected_digests.push_back(h);
			in_message = 1'b0;
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// queue one message; occasional junk in byte_count and above the tail
	task automatic queue_message(int unsigned words, int unsigned tail_cnt, bit noisy);
		word_beat_t b;
		for (int i = 0; i < words; i++) begin
			b.data = rand64();
			b.cnt = (noisy && $urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
			b.last = 1'b0;
			pending_beats.push_back(b);
		end
		b.data = rand64();
		b.cnt = 4'(tail_cnt);
		b.last = 1'b1;
		pending_beats.push_back(b);
	endtask

	// driver: a held sender only stops between messages
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			word_data <= '0;
			byte_count <= '0;
			last_word <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_beat('{word_data, byte_count, last_word});
				void'(pending_beats.pop_front());
			end
			if (!in_valid || !in_stall) begin
				// current beat gone: offer the next one or idle
				if (pending_beats.size() > 0 && (!hold_sender || in_message) &&
					(idle_free || $urandom_range(99) >= 12)) begin
					in_valid <= 1'b1;
					word_data <= pending_beats[0].data;
					byte_count <= pending_beats[0].cnt;
					last_word <= pending_beats[0].last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_digests.size() == 0) begin
					$error("unexpected digest beat: %h", digest);
					error_count++;
				end else if (digest !== expected_digests[0]) begin
					$error("digest: expected %h, actual %h", expected_digests[0], digest);
					error_count++;
					void'(expected_digests.pop_front());
				end else begin
					void'(expected_digests.pop_front());
				end
			end
			out_stall <= !idle_free && ($urandom_range(99) < 12);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || expected_digests.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		hash_seed = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned n;
		idle_free = 1'b0;
		hold_sender = 1'b0;
		hash_seed = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset seed, empty message, every tail size, stripe edges
		queue_message(0, 0, 0);
		for (int t = 1; t <= 8; t++) queue_message(0, t, 0);
		queue_message(3, 5, 0);
		queue_message(4, 0, 0);
		queue_message(4, 8, 0);
		queue_message(7, 3, 0);
		queue_message(1, 15, 0);          // byte count saturates
		queue_message(2, 6, 1);           // odd byte_count on inner words
		wait_drained();

		write_seed('1);
		begin
			word_beat_t b;
			b = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1};
			pending_beats.push_back(b);
			b = '{64'h0, 4'd8, 1'b0};
			pending_beats.push_back(b);
			b = '{64'h0, 4'd9, 1'b1};
			pending_beats.push_back(b);
		end
		queue_message(5, 7, 0);
		wait_drained();

		// random phases with different seeds
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_seed('0);
				1: write_seed(64'h8000_0000_0000_0000);
				default: write_seed(rand64());
			endcase
			idle_free = (phase == 2);
			n = 0;
			while (n < 90) begin
				int unsigned words;
				words = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(9);
				queue_message(words, $urandom_range(9) == 0 ? $urandom_range(15) :
					$urandom_range(8), $urandom_range(4) == 0);
				n += words + 1;
				if (phase == 3 && n > 50 && !hold_sender) begin
					// pause the sender until every digest so far is back
					hold_sender = 1'b1;
					while (in_valid || expected_digests.size() > 0 ||
						in_message) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			wait_drained();
		end

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/xxh64_pkg.sv
src/xxh64_datapath.sv
src/xxh64_ctrl.sv
src/xxh64_stream_hash.sv
tb/sv/tb.sv
